// ===== sv/idm_pkg.sv =====
// Package for the identifier mangler: payload structs, queue entry type,
// hash and character constants, and the hex digit helper. No dependencies.
`timescale 1ns / 1ps

package idm_pkg;

  // Input transaction: one raw identifier byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } idm_in_t;

  // Output transaction: one mangled byte or one suffix character.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } idm_out_t;

  // Width of the folded hash; congruent to the hash but not fully reduced.
  localparam int unsigned FoldW = 32;

  // One classified byte on its way from the front end to the back end.
  typedef struct packed {
    logic [7:0]       mbyte;   // mangled byte
    logic             last;    // final byte of the name
    logic             suffix;  // hash suffix follows this byte
    logic [FoldW-1:0] fold;    // folded hash, meaningful when suffix is set
  } idm_entry_t;

  localparam logic [24:0] HashMult   = 25'd27823485;
  localparam logic [30:0] HashMod    = 31'h7FFF_FFFF;
  localparam logic [7:0]  CharUscore = 8'h5F;
  localparam logic [7:0]  CharZero   = 8'h30;
  localparam logic [7:0]  CharUpperA = 8'h41;
  localparam logic [7:0]  CaseShift  = 8'h20;  // 'a' - 'A'

  // Upper-case hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {4'b0, nib};
    end else begin
      res = CharUpperA + {4'b0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

// ===== sv/idm_front.sv =====
// Front end of the identifier mangler: classifies each byte, keeps the sticky
// flag and the running hash, and pushes one entry per byte. Uses idm_pkg.
`timescale 1ns / 1ps

module idm_front import idm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  idm_in_t    in_data_i,
  output logic       push_o,
  input  logic       full_i,
  output idm_entry_t entry_o
);

  logic             first_q, first_d;
  logic             flag_q, flag_d;
  logic [FoldW-1:0] fold_q, fold_d;

  logic [7:0]       c;
  logic [7:0]       mbyte;
  logic             sets_flag;
  logic [56:0]      prod;
  logic [FoldW-1:0] fold_new;
  logic             take;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign push_o     = take;
  assign c          = in_data_i.in_byte;

  always_comb begin
    mbyte     = CharUscore;
    sets_flag = 1'b0;
    if (c inside {[8'h61:8'h7A]}) begin
      mbyte     = c - CaseShift;
      sets_flag = 1'b1;
    end else if (c inside {[8'h41:8'h5A], [8'h30:8'h39]}) begin
      mbyte = c;
    end else begin
      sets_flag = (c != CharUscore);
    end
  end

  // The running value is kept folded (below 2^31 + 2^26), so one multiply
  // and one add close the loop each byte; the final reduction is done later.
  always_comb begin
    prod = 57'(fold_q) * 57'(HashMult) + 57'(c);
    if (first_q) begin
      fold_new = FoldW'(c);
    end else begin
      fold_new = FoldW'(prod[30:0]) + FoldW'(prod[56:31]);
    end
  end

  always_comb begin
    first_d = first_q;
    flag_d  = flag_q;
    fold_d  = fold_q;
    if (take) begin
      if (in_data_i.in_last) begin
        first_d = 1'b1;
        flag_d  = 1'b0;
        fold_d  = '0;
      end else begin
        first_d = 1'b0;
        flag_d  = flag_q || sets_flag;
        fold_d  = fold_new;
      end
    end
  end

  assign entry_o.mbyte  = mbyte;
  assign entry_o.last   = in_data_i.in_last;
  assign entry_o.suffix = in_data_i.in_last && (flag_q || sets_flag);
  assign entry_o.fold   = fold_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      flag_q  <= 1'b0;
      fold_q  <= '0;
    end else begin
      first_q <= first_d;
      flag_q  <= flag_d;
      fold_q  <= fold_d;
    end
  end

endmodule

// ===== sv/idm_fifo.sv =====
// Short queue of classified entries between the front and back ends.
// Uses idm_pkg for the entry type.
`timescale 1ns / 1ps

module idm_fifo import idm_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  idm_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output idm_entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  idm_entry_t      slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/idm_back.sv =====
// Back end of the identifier mangler: emits the mangled byte of each entry
// and, where flagged, the underscore and eight hex digits. Uses idm_pkg.
`timescale 1ns / 1ps

module idm_back import idm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  idm_entry_t q_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output idm_out_t   out_data_o
);

  localparam logic [3:0] StepByte  = 4'd0;
  localparam logic [3:0] StepSep   = 4'd1;
  localparam logic [3:0] StepFirst = 4'd2;
  localparam logic [3:0] StepFinal = 4'd9;

  logic        busy_q, busy_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  mbyte_q, mbyte_d;
  logic        last_q, last_d;
  logic        suffix_q, suffix_d;
  logic [30:0] hash_q, hash_d;

  logic        done;
  logic        fire;
  logic [2:0]  didx;
  logic [3:0]  digit;
  logic [30:0] reduced;

  assign done = ((step_q == StepByte) && !suffix_q) || (step_q == StepFinal);
  assign fire = busy_q && out_ready_i;
  assign pop_o = q_valid_i && (!busy_q || (fire && done));

  // Fold value is below twice the modulus, so one subtract finishes it.
  assign reduced = 31'((q_data_i.fold >= {1'b0, HashMod}) ?
                       q_data_i.fold - {1'b0, HashMod} : q_data_i.fold);

  // Most significant digit first: digit k sits at bit 28 - 4k.
  assign didx  = 3'(step_q - StepFirst);
  assign digit = 4'({1'b0, hash_q} >> {~didx, 2'b00});

  always_comb begin
    out_valid_o         = busy_q;
    out_data_o.out_last = done && last_q;
    if (step_q == StepByte) begin
      out_data_o.out_byte = mbyte_q;
    end else if (step_q == StepSep) begin
      out_data_o.out_byte = CharUscore;
    end else begin
      out_data_o.out_byte = hex_char(digit);
    end
  end

  always_comb begin
    busy_d   = busy_q;
    step_d   = step_q;
    mbyte_d  = mbyte_q;
    last_d   = last_q;
    suffix_d = suffix_q;
    hash_d   = hash_q;
    if (pop_o) begin
      busy_d   = 1'b1;
      step_d   = StepByte;
      mbyte_d  = q_data_i.mbyte;
      last_d   = q_data_i.last;
      suffix_d = q_data_i.suffix;
      hash_d   = reduced;
    end else if (fire) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepByte;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mbyte_q  <= mbyte_d;
    last_q   <= last_d;
    suffix_q <= suffix_d;
    hash_q   <= hash_d;
  end

endmodule

// ===== sv/identifier_mangler_with_hash.sv =====
// Top level of the identifier mangler: front end, entry queue and back end.
// Depends on idm_pkg, idm_front, idm_fifo and idm_back.
`timescale 1ns / 1ps

// Usage
// The input channel takes one identifier byte per transaction, with in_last
// set on the final byte of a name. The output channel gives one transaction
// per mangled byte: lower case turned to upper case, upper case and digits
// unchanged, anything else an underscore. When a name held a lower-case
// letter or a replaced byte other than an underscore, its last byte is
// followed by an underscore and eight upper-case hex digits of the hash
// h = (h * 27823485 + c) mod (2^31 - 1), the first byte loading h = c.
// Throughput is one byte per cycle on both sides when nothing stalls; a
// name with a suffix occupies the output for nine further transactions,
// during which input bytes keep arriving into the queue until it fills. A
// byte passes through the queue and then the output register before its
// first output transaction. The hash recurrence is closed every cycle by a
// single multiply and add in the front end, which sets the rate. Reset
// clears the running hash, the sticky flag, the queue and the output stage;
// the next byte starts a name. When the receiver stalls, the output holds,
// the queue fills, and in_ready_o drops once QueueDepth entries wait.
module identifier_mangler_with_hash import idm_pkg::*; #(
  parameter int unsigned QueueDepth = 2  // entries between front and back, at least 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  idm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output idm_out_t out_data_o
);

  idm_entry_t push_entry;
  idm_entry_t head_entry;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;

  // The front end classifies each byte in the cycle of its transaction and
  // advances the folded hash; the hash is used only from the final byte's entry.
  idm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  // The queue decouples the two halves, so input keeps flowing while the
  // back end spells out a suffix or the receiver stalls.
  idm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .pop_data_o  (head_entry)
  );

  // The back end holds the current entry in registers and steps through the
  // mangled byte and, where required, the suffix characters.
  idm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (head_valid),
    .q_data_i    (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/mangled_stream_checker.sv =====
// Checker for the identifier mangler: watches both channels, predicts the mangled stream
// with hash suffix, and compares each output transaction. Depends on idm_pkg.
`timescale 1ns / 1ps

module mangled_stream_checker import idm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  idm_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  idm_out_t    out_data_i,
  output int unsigned mismatches_o,
  output int unsigned awaited_o
);

  localparam logic [7:0]  LowA       = 8'h61;
  localparam logic [7:0]  LowZ       = 8'h7A;
  localparam logic [7:0]  UpA        = 8'h41;
  localparam logic [7:0]  UpZ        = 8'h5A;
  localparam logic [7:0]  Dig0       = 8'h30;
  localparam logic [7:0]  Dig9       = 8'h39;
  localparam logic [7:0]  Under      = 8'h5F;
  localparam logic [7:0]  CaseGap    = 8'h20;
  localparam logic [63:0] HashFactor = 64'd27823485;
  localparam logic [63:0] Mersenne31 = 64'h7FFF_FFFF;

  idm_out_t    awaited_bytes[$];
  logic [30:0] run_hash = '0;
  logic        name_fresh = 1'b1;
  logic        name_tainted = 1'b0;
  int unsigned mismatch_n = 0;
  idm_out_t    due;

  assign mismatches_o = mismatch_n;

  function automatic logic [7:0] hex_symbol(input logic [3:0] nib);
    return (nib > 4'd9) ? (UpA + {4'b0, nib - 4'd10}) : (Dig0 + {4'b0, nib});
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic last);
    idm_out_t e;
    e.out_byte = b;
    e.out_last = last;
    awaited_bytes.push_back(e);
  endtask

  // Works out every output byte that one accepted input byte causes.
  task automatic predict_mangled_bytes(input idm_in_t txn);
    logic [7:0]  c;
    logic [7:0]  m;
    logic [63:0] prod;
    logic [31:0] h32;
    c = txn.in_byte;
    if (c >= LowA && c <= LowZ) begin
      m = c - CaseGap;
      name_tainted = 1'b1;
    end else if ((c >= UpA && c <= UpZ) || (c >= Dig0 && c <= Dig9)) begin
      m = c;
    end else begin
      m = Under;
      if (c != Under) name_tainted = 1'b1;
    end
    if (name_fresh) begin
      run_hash = {23'b0, c};
    end else begin
      prod = {33'b0, run_hash} * HashFactor + {56'b0, c};
      run_hash = 31'(prod % Mersenne31);
    end
    name_fresh = 1'b0;
    if (!txn.in_last) begin
      expect_byte(m, 1'b0);
    end else begin
      if (!name_tainted) begin
        expect_byte(m, 1'b1);
      end else begin
        expect_byte(m, 1'b0);
        expect_byte(Under, 1'b0);
        h32 = {1'b0, run_hash};
        for (int k = 7; k >= 0; k--) begin
          expect_byte(hex_symbol(h32[k*4 +: 4]), k == 0);
        end
      end
      run_hash = '0;
      name_fresh = 1'b1;
      name_tainted = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_bytes.delete();
      run_hash = '0;
      name_fresh = 1'b1;
      name_tainted = 1'b0;
      awaited_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_mangled_bytes(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_bytes.size() == 0) begin
          if (mismatch_n < 10)
            $display("%0t: unexpected output byte %h last %b", $realtime,
                     out_data_i.out_byte, out_data_i.out_last);
          mismatch_n++;
        end else begin
          due = awaited_bytes.pop_front();
          if (due.out_byte !== out_data_i.out_byte || due.out_last !== out_data_i.out_last)
          begin
            if (mismatch_n < 10)
              $display("%0t: mismatch: out_byte exp %h got %h, out_last exp %b got %b",
                       $realtime, due.out_byte, out_data_i.out_byte, due.out_last,
                       out_data_i.out_last);
            mismatch_n++;
          end
        end
      end
      awaited_o <= awaited_bytes.size();
    end
  end

endmodule

// ===== verif/identifier_mangler_with_hash_test.sv =====
// Testbench top for the identifier mangler: clock, reset, name stimulus and output stalls.
// Depends on idm_pkg, identifier_mangler_with_hash and mangled_stream_checker.
`timescale 1ns / 1ps

module identifier_mangler_with_hash_test;
  import idm_pkg::*;

  // Character bounds used to build names; each class of byte drives a
  // different branch of the mangling rules.
  localparam logic [7:0]  LowA  = 8'h61;
  localparam logic [7:0]  LowZ  = 8'h7A;
  localparam logic [7:0]  UpA   = 8'h41;
  localparam logic [7:0]  UpZ   = 8'h5A;
  localparam logic [7:0]  Dig0  = 8'h30;
  localparam logic [7:0]  Dig9  = 8'h39;
  localparam logic [7:0]  Under = 8'h5F;

  // Roughly 380 bytes in all, the directed ones included.
  localparam int unsigned TotalBytes  = 380;
  localparam int unsigned PauseAt     = 200;
  localparam int unsigned DrainCycles = 20;
  // The slowest correct run has every byte followed by ten results, each
  // given the longest stall, plus the sender's gaps; the limit sits well above it.
  localparam int unsigned CycleLimit  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  idm_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  idm_out_t    out_data;
  int unsigned mismatches;
  int unsigned awaited;

  logic [7:0]  name_buf[$];
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;

  // Receiver state: a hold count for the current stall, and a phase flag
  // which, when set, gives a stretch with no stalls at all.
  int unsigned rx_hold = 0;
  int unsigned rx_phase_left = 0;
  logic        rx_calm = 1'b0;
  int unsigned rx_draw;

  identifier_mangler_with_hash u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  mangled_stream_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .awaited_o   (awaited)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Guard against a hung block: the run ends as a failure if the limit is reached.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("identifier_mangler_with_hash_test: FAIL");
      $finish;
    end
  end

  // Receiver side. After every accepted output transaction a fresh stall
  // length is drawn at random, except during calm phases, so that stalls land
  // on the mangled byte, the underscore and each hex digit of a suffix.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
      rx_calm <= 1'b0;
      rx_phase_left <= 0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_calm <= ($urandom_range(0, 2) == 0);
        rx_phase_left <= $urandom_range(20, 120);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      if (out_valid && out_ready) begin
        rx_draw = rx_calm ? 0 : $urandom_range(0, 17);
        rx_hold <= rx_draw;
        out_ready <= (rx_draw == 0);
      end else if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= (rx_hold == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one byte after a gap of the given length and waits for the
  // transaction. Valid stays high straight into the next byte when there is
  // no gap, so back-to-back transactions are exercised as well.
  task automatic send_raw_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the name held in name_buf, flagging its final byte. A calm name
  // is sent with no gaps between its bytes.
  task automatic send_name_buf(input bit calm);
    for (int i = 0; i < name_buf.size(); i++) begin
      send_raw_byte(name_buf[i], i == name_buf.size() - 1, calm ? 0 : $urandom_range(0, 17));
    end
  endtask

  // Stops offering bytes until every predicted result has been received.
  // The checker's count is registered, hence the wait for an edge before the loop.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // A clean name uses only upper case, digits and underscores, so it gets
  // no suffix; otherwise lower case and arbitrary bytes join in, the latter
  // covering every bit of the byte field.
  function automatic logic [7:0] pick_char(input bit clean);
    logic [7:0] ch;
    case (clean ? $urandom_range(0, 2) : $urandom_range(0, 5))
      0:       ch = UpA + 8'($urandom_range(0, 25));
      1:       ch = Dig0 + 8'($urandom_range(0, 9));
      2:       ch = Under;
      3:       ch = LowA + 8'($urandom_range(0, 25));
      default: ch = 8'($urandom_range(0, 255));
    endcase
    return ch;
  endfunction

  initial begin
    int unsigned name_len;
    bit          clean;
    bit          paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names: single-byte letters of both cases, the zero byte, the
    // top byte values, a lone underscore, clean names that end without a
    // suffix, and the bytes just outside each letter and digit range.
    name_buf = '{LowA};
    send_name_buf(1'b1);
    name_buf = '{UpZ};
    send_name_buf(1'b1);
    name_buf = '{8'h00};
    send_name_buf(1'b0);
    name_buf = '{8'hFF};
    send_name_buf(1'b1);
    name_buf = '{Under};
    send_name_buf(1'b0);
    name_buf = '{8'h80};
    send_name_buf(1'b1);
    name_buf = '{Dig0, Dig9};
    send_name_buf(1'b1);
    name_buf = '{UpA, Under, UpZ};
    send_name_buf(1'b0);
    name_buf = '{LowZ, Dig9, Under, UpA};
    send_name_buf(1'b1);
    name_buf = '{8'h60, 8'h7B, 8'h40, 8'h5B, 8'h2F, 8'h3A};
    send_name_buf(1'b0);

    // Random names, mostly short, now and then long enough to run the
    // hash through many rounds.
    while (bytes_sent < TotalBytes) begin
      name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      clean = ($urandom_range(0, 2) == 0);
      name_buf.delete();
      repeat (name_len) name_buf.push_back(pick_char(clean));
      send_name_buf($urandom_range(0, 3) == 0);
      if (!paused && bytes_sent >= PauseAt) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("identifier_mangler_with_hash_test: PASS");
    end else begin
      $display("identifier_mangler_with_hash_test: FAIL");
    end
    $finish;
  end

endmodule
